// File: hdl/gpcb_pkg.sv
// Shared types, command codes and bank constants for the GPIO pin configuration block.
`timescale 1ns / 1ps

package gpcb_pkg;

  localparam int PORT_COUNT    = 8;
  localparam int PINS_PER_PORT = 16;
  localparam int STORE_DEPTH   = 128;
  localparam int PIN_W         = $clog2(STORE_DEPTH);
  localparam int PIN_TOTAL     = PORT_COUNT * PINS_PER_PORT;
  localparam int PIN_LIMIT     = (PIN_TOTAL < STORE_DEPTH) ? PIN_TOTAL : STORE_DEPTH;
  localparam int LIMIT_W       = PIN_W + 1;

  typedef enum logic [2:0] {
    CMD_SET_MODE   = 3'd0,
    CMD_SET_OTYPE  = 3'd1,
    CMD_SET_SPEED  = 3'd2,
    CMD_SET_PULL   = 3'd3,
    CMD_SET_ALTFN  = 3'd4,
    CMD_SET_LATCH  = 3'd5,
    CMD_CLR_LATCH  = 3'd6,
    CMD_READ_PAD   = 3'd7
  } cmd_e;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_NOT_ALT   = 2'd2;

  localparam logic [1:0] MODE_ALTERNATE   = 2'b10;
  localparam logic [3:0] MAX_TWO_BIT      = 4'd3;
  localparam logic [3:0] MAX_ONE_BIT      = 4'd1;

  typedef struct packed {
    logic [2:0]       command;
    logic [PIN_W-1:0] pin_index;
    logic [3:0]       value;
    logic             pad_level;
  } gpio_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       read_level;
    logic [1:0] pin_mode;
    logic       pin_open_drain;
    logic [1:0] pin_speed;
    logic [1:0] pin_pull;
    logic [3:0] pin_alt_func;
    logic       pin_out_level;
  } gpio_out_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       open_drain;
    logic [1:0] speed;
    logic [1:0] pull;
    logic [3:0] alt_func;
    logic       out_level;
  } pin_cfg_t;

endpackage

// File: hdl/gpcb_pin_store.sv
// Per-pin settings memory with reset-clear valid bits and write-to-read forwarding.
`timescale 1ns / 1ps

module gpcb_pin_store
  import gpcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [PIN_W-1:0] rd_addr_i,
  output pin_cfg_t         rd_data_o,
  input  logic             wr_en_i,
  input  logic [PIN_W-1:0] wr_addr_i,
  input  pin_cfg_t         wr_data_i
);

  pin_cfg_t               mem_q [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  pin_cfg_t               raw_q;
  pin_cfg_t               fwd_data_q;
  logic                   hit_q;
  logic                   fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      raw_q      <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= vld_q[rd_addr_i];
        fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // Entries never written since reset read as all zero.
  assign rd_data_o = fwd_q ? fwd_data_q : (hit_q ? raw_q : '0);

endmodule

// File: hdl/gpcb_cmd_exec.sv
// Applies one command to the addressed pin's settings and forms the result item.
`timescale 1ns / 1ps

module gpcb_cmd_exec
  import gpcb_pkg::*;
(
  input  gpio_in_t  item_i,
  input  pin_cfg_t  cur_i,
  output pin_cfg_t  next_o,
  output logic      wr_en_o,
  output gpio_out_t result_o
);

  logic       in_range;
  logic [1:0] status;
  logic       rd_level;
  pin_cfg_t   nxt;

  assign in_range = ({1'b0, item_i.pin_index} < LIMIT_W'(PIN_LIMIT));

  always_comb begin
    nxt      = cur_i;
    status   = STATUS_OK;
    rd_level = 1'b0;
    case (cmd_e'(item_i.command))
      CMD_SET_MODE: begin
        if (item_i.value > MAX_TWO_BIT) status = STATUS_RANGE;
        else nxt.mode = item_i.value[1:0];
      end
      CMD_SET_OTYPE: begin
        if (item_i.value > MAX_ONE_BIT) status = STATUS_RANGE;
        else nxt.open_drain = item_i.value[0];
      end
      CMD_SET_SPEED: begin
        if (item_i.value > MAX_TWO_BIT) status = STATUS_RANGE;
        else nxt.speed = item_i.value[1:0];
      end
      CMD_SET_PULL: begin
        if (item_i.value > MAX_TWO_BIT) status = STATUS_RANGE;
        else nxt.pull = item_i.value[1:0];
      end
      CMD_SET_ALTFN: begin
        if (cur_i.mode != MODE_ALTERNATE) status = STATUS_NOT_ALT;
        else nxt.alt_func = item_i.value;
      end
      CMD_SET_LATCH: nxt.out_level = 1'b1;
      CMD_CLR_LATCH: nxt.out_level = 1'b0;
      default:       rd_level = item_i.pad_level;
    endcase
  end

  assign next_o  = nxt;
  assign wr_en_o = in_range;

  always_comb begin
    if (in_range) begin
      result_o.status         = status;
      result_o.read_level     = rd_level;
      result_o.pin_mode       = nxt.mode;
      result_o.pin_open_drain = nxt.open_drain;
      result_o.pin_speed      = nxt.speed;
      result_o.pin_pull       = nxt.pull;
      result_o.pin_alt_func   = nxt.alt_func;
      result_o.pin_out_level  = nxt.out_level;
    end else begin
      result_o        = '0;
      result_o.status = STATUS_RANGE;
    end
  end

endmodule

// File: hdl/gpio_pin_config_block_top.sv
// Top level of the GPIO pin configuration block: input stage, settings memory, result register.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o   in_item_i  (gpio_in_t)
//   out      output     out_valid_o / out_ready_i out_item_o (gpio_out_t)
//
// An item is accepted into the execute stage while the pin's settings are read from
// the memory; the command is applied in the execute stage and, as the item leaves it,
// the entry is written back and the result registered. One item is taken every cycle
// unless the output stalls; the memory is read at the accepting edge and written back
// as the item leaves, with a forward path covering back-to-back items to the same pin.
// Reset clears a valid bit per pin, so every pin reads as all zero at once after reset.
// A stalled output holds the execute stage, which in turn lowers in_ready_o.
`timescale 1ns / 1ps

module gpio_pin_config_block_top
  import gpcb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gpio_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output gpio_out_t out_item_o
);

  // Execute stage: the accepted item waits here while its pin's entry is read.
  logic      exe_valid_q;
  gpio_in_t  exe_item_q;
  logic      exe_adv;
  logic      in_fire;

  // Result register.
  logic      out_valid_q;
  gpio_out_t out_item_q;

  pin_cfg_t  cur_cfg;
  pin_cfg_t  next_cfg;
  logic      cfg_wr;
  gpio_out_t result;

  // The execute stage moves on whenever the result register is free or being emptied.
  assign exe_adv    = exe_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !exe_valid_q || exe_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  gpcb_pin_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_item_i.pin_index),
    .rd_data_o (cur_cfg),
    .wr_en_i   (exe_adv && cfg_wr),
    .wr_addr_i (exe_item_q.pin_index),
    .wr_data_i (next_cfg)
  );

  gpcb_cmd_exec u_exec (
    .item_i   (exe_item_q),
    .cur_i    (cur_cfg),
    .next_o   (next_cfg),
    .wr_en_o  (cfg_wr),
    .result_o (result)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      exe_item_q <= in_item_i;
    end
    if (exe_adv) begin
      out_item_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exe_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        exe_valid_q <= in_valid_i;
      end
      if (exe_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
